// File: rtl/tgap_pkg.sv
// Shared types, constants and header offsets for the TGA pixel parser.
package tgap_pkg;

    // Default width of the pixel buffer address
    localparam int ADDR_BITS_DEF = 32;

    // Stream word widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 2;
    localparam int INDEX_W   = 32;

    // Header byte offsets
    localparam logic [4:0] HDR_ID_LEN       = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE     = 5'd1;
    localparam logic [4:0] HDR_IMAGE_TYPE   = 5'd2;
    localparam logic [4:0] HDR_MAP_FIRST_LO = 5'd3;
    localparam logic [4:0] HDR_MAP_FIRST_HI = 5'd4;
    localparam logic [4:0] HDR_MAP_LEN_LO   = 5'd5;
    localparam logic [4:0] HDR_MAP_LEN_HI   = 5'd6;
    localparam logic [4:0] HDR_MAP_DEPTH    = 5'd7;
    localparam logic [4:0] HDR_WIDTH_LO     = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI     = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO    = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI    = 5'd15;
    localparam logic [4:0] HDR_DEPTH        = 5'd16;
    localparam logic [4:0] HDR_DESCRIPTOR   = 5'd17;

    // Header field values
    localparam logic [7:0] IMAGE_TYPE_TRUECOLOUR = 8'd2;
    localparam logic [7:0] DEPTH_24              = 8'd24;
    localparam logic [7:0] DEPTH_32              = 8'd32;
    localparam logic [7:0] DESC_24               = 8'd0;
    localparam logic [7:0] DESC_32               = 8'd8;
    localparam logic [7:0] ALPHA_OPAQUE          = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_PIXELS = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FIXED = 2'd1,
        ERR_DESC  = 2'd2,
        ERR_DEPTH = 2'd3
    } t_err;

    // Input word held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       sof;
    } t_in_word;

    // One result word
    typedef struct packed {
        t_kind               kind;
        logic [31:0]         bgra;
        logic [INDEX_W-1:0]  index;
        logic [15:0]         width;
        logic [15:0]         height;
        t_err                err;
        logic                final_item;
    } t_result;

endpackage

// File: rtl/tgap_in_reg.sv
// Input register: holds one incoming byte until the parser takes it.
module tgap_in_reg
    import tgap_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]           s_axis_tuser,   // [0] start_of_file
    input  logic                 i_take,
    output t_in_word             o_word
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_sof;

    // free when empty or when the held word leaves this cycle
    assign s_axis_tready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata[7:0];
            r_sof  <= s_axis_tuser[0];
        end
    end

    assign o_word = '{valid: r_valid, data_byte: r_byte, sof: r_sof};

endmodule

// File: rtl/tgap_parser.sv
// Header check and pixel assembly state, one byte per cycle while a byte is taken.
module tgap_parser
    import tgap_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_word i_word,
    input  logic     i_take,
    output logic     o_res_valid,
    output t_result  o_res
);

    t_phase                r_phase, n_phase;
    logic [4:0]            r_hpos, n_hpos;
    logic [15:0]           r_width, n_width;
    logic [15:0]           r_height, n_height;
    logic                  r_d32, n_d32;
    logic [23:0]           r_held, n_held;
    logic [1:0]            r_bip, n_bip;
    logic [15:0]           r_col, n_col;
    logic [15:0]           r_rows, n_rows;
    logic [ADDR_BITS-1:0]  r_base, n_base;

    logic                  sof;
    logic [7:0]            b;
    t_phase                e_phase;
    logic [4:0]            e_hpos;
    logic [1:0]            last_byte;
    logic                  row_end;
    logic                  empty;
    logic [31:0]           base_prod;
    logic [ADDR_BITS-1:0]  idx;

    assign sof = i_take && i_word.sof;
    assign b   = i_word.data_byte;

    // start row base for the bottom-up file order, top row is 0
    assign base_prod = r_width * (r_height - 16'd1);
    assign idx       = ADDR_BITS'(r_base + ADDR_BITS'(r_col));
    assign row_end   = ({1'b0, r_col} + 17'd1) >= {1'b0, r_width};
    assign empty     = (r_width == 16'd0) || (r_height == 16'd0);
    assign last_byte = r_d32 ? 2'd3 : 2'd2;

    // next state and result
    always_comb begin
        e_phase     = sof ? PH_HEADER : r_phase;
        e_hpos      = sof ? 5'd0 : r_hpos;
        n_phase     = e_phase;
        n_hpos      = e_hpos;
        n_width     = sof ? 16'd0 : r_width;
        n_height    = sof ? 16'd0 : r_height;
        n_d32       = r_d32;
        n_held      = sof ? 24'd0 : r_held;
        n_bip       = sof ? 2'd0 : r_bip;
        n_col       = r_col;
        n_rows      = r_rows;
        n_base      = r_base;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_take) begin
            case (e_phase)
                PH_HEADER: begin
                    n_hpos = e_hpos + 5'd1;
                    case (e_hpos)
                        HDR_ID_LEN, HDR_MAP_TYPE, HDR_MAP_FIRST_LO, HDR_MAP_FIRST_HI,
                        HDR_MAP_LEN_LO, HDR_MAP_LEN_HI, HDR_MAP_DEPTH: begin
                            if (b != 8'd0) begin
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_ERROR;
                                o_res.err   = ERR_FIXED;
                                n_phase     = PH_IDLE;
                            end
                        end
                        HDR_IMAGE_TYPE: begin
                            if (b != IMAGE_TYPE_TRUECOLOUR) begin
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_ERROR;
                                o_res.err   = ERR_FIXED;
                                n_phase     = PH_IDLE;
                            end
                        end
                        HDR_WIDTH_LO:  n_width  = {8'd0, b};
                        HDR_WIDTH_HI:  n_width  = {b, n_width[7:0]};
                        HDR_HEIGHT_LO: n_height = {8'd0, b};
                        HDR_HEIGHT_HI: n_height = {b, n_height[7:0]};
                        HDR_DEPTH:     n_held   = {16'd0, b};
                        HDR_DESCRIPTOR: begin
                            o_res_valid = 1'b1;
                            if ((r_held[7:0] != DEPTH_24) && (r_held[7:0] != DEPTH_32)) begin
                                o_res.kind = KIND_ERROR;
                                o_res.err  = ERR_DEPTH;
                                n_phase    = PH_IDLE;
                            end else if (((r_held[7:0] == DEPTH_24) && (b != DESC_24)) ||
                                         ((r_held[7:0] == DEPTH_32) && (b != DESC_32))) begin
                                o_res.kind = KIND_ERROR;
                                o_res.err  = ERR_DESC;
                                n_phase    = PH_IDLE;
                            end else begin
                                n_d32            = (r_held[7:0] == DEPTH_32);
                                n_held           = 24'd0;
                                n_bip            = 2'd0;
                                n_col            = 16'd0;
                                n_rows           = r_height;
                                n_base           = empty ? '0 : ADDR_BITS'(base_prod);
                                n_phase          = empty ? PH_IDLE : PH_PIXELS;
                                o_res.kind       = KIND_HEADER;
                                o_res.width      = r_width;
                                o_res.height     = r_height;
                                o_res.final_item = empty;
                            end
                        end
                        default: ;  // origins are ignored
                    endcase
                end
                PH_PIXELS: begin
                    if (r_bip < last_byte) begin
                        // collect the colour bytes
                        case (r_bip)
                            2'd0:    n_held = r_held | {16'd0, b};
                            2'd1:    n_held = r_held | {8'd0, b, 8'd0};
                            default: n_held = r_held | {b, 16'd0};
                        endcase
                        n_bip = r_bip + 2'd1;
                    end else begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_PIXEL;
                        o_res.bgra       = r_d32 ? {b, r_held}
                                                 : {ALPHA_OPAQUE, b, r_held[15:0]};
                        o_res.index      = INDEX_W'(idx);
                        o_res.width      = r_width;
                        o_res.height     = r_height;
                        o_res.final_item = (r_rows <= 16'd1) && row_end;
                        n_held           = 24'd0;
                        n_bip            = 2'd0;
                        if (row_end) begin
                            n_col  = 16'd0;
                            n_rows = r_rows - 16'd1;
                            n_base = ADDR_BITS'(r_base - ADDR_BITS'(r_width));
                        end else begin
                            n_col = r_col + 16'd1;
                        end
                        if ((r_rows <= 16'd1) && row_end) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: ;  // idle: bytes dropped
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hpos   <= 5'd0;
            r_width  <= 16'd0;
            r_height <= 16'd0;
            r_d32    <= 1'b0;
            r_held   <= 24'd0;
            r_bip    <= 2'd0;
            r_col    <= 16'd0;
            r_rows   <= 16'd0;
            r_base   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_hpos   <= n_hpos;
            r_width  <= n_width;
            r_height <= n_height;
            r_d32    <= n_d32;
            r_held   <= n_held;
            r_bip    <= n_bip;
            r_col    <= n_col;
            r_rows   <= n_rows;
            r_base   <= n_base;
        end
    end

`ifndef ASSERT_OFF
    // an image in progress always has a row left
    a_rows_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PIXELS |-> r_rows != 16'd0)
        else $error("pixel phase with no rows left");

    // pixels only come out of the pixel phase
    a_pixel_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_PIXEL) |-> (r_phase == PH_PIXELS && !sof))
        else $error("pixel emitted outside pixel phase");

    // header result only on the descriptor byte
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_HEADER) |-> (r_hpos == HDR_DESCRIPTOR))
        else $error("header result at wrong byte");

    // an error result of the parser sends the block to idle
    a_error_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_ERROR) |=> r_phase == PH_IDLE)
        else $error("parser not idle after error");
`endif

endmodule

// File: rtl/tgap_out_reg.sv
// Result register on the master side of the stream.
module tgap_out_reg
    import tgap_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_word_valid,
    input  logic                 i_res_valid,
    input  t_result              i_res,
    output logic                 o_take,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // bgra, index, width, height, error_code
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // [1:0] result_kind
    output logic                 m_axis_tlast    // final_item
);

    logic    r_valid;
    t_result r_res;
    logic    load;

    // the parser moves on when the result slot is free or draining
    assign o_take = i_word_valid && (!r_valid || m_axis_tready);
    assign load   = o_take && i_res_valid;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'd0, r_res.err, r_res.height, r_res.width,
                            r_res.index, r_res.bgra};
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tlast  = r_res.final_item;

endmodule

// File: rtl/tga_uncompressed_pixel_parser.sv
// Each byte is held in the input register; its result is held in the result register.
// Throughput: one byte per cycle if not stalled; a pixel every 3 (24-bit) or 4 (32-bit) bytes.
// The rate is set by the single parse step between the input and result registers.
// Row base is stepped by one subtract per row; one 16x16 multiply runs on the last header byte.
// Reset is synchronous, active low, and clears all control and parse state at once.
module tga_uncompressed_pixel_parser
    import tgap_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]           s_axis_tuser,   // [0] start_of_file
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] pixel_bgra, [63:32] pixel_index,
                                                 // [79:64] image_width, [95:80] image_height,
                                                 // [97:96] error_code, [103:98] zero
    output logic [M_TUSER_W-1:0] m_axis_tuser,   // [1:0] result_kind
    output logic                 m_axis_tlast    // final_item
);

    t_in_word word;
    logic     take;
    logic     res_valid;
    t_result  res;

    // input word register
    tgap_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (take),
        .o_word        (word)
    );

    // parse step
    tgap_parser #(
        .ADDR_BITS (ADDR_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (word),
        .i_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result word register
    tgap_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word_valid  (word.valid),
        .i_res_valid   (res_valid),
        .i_res         (res),
        .o_take        (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: bench/tb_tga_uncompressed_pixel_parser.sv
// Self-checking bench for the TGA pixel parser: directed header table, then random files.
module tb_tga_uncompressed_pixel_parser;
    import tgap_pkg::*;

    localparam int N_ITEMS          = 1400;
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int MAX_TRUNC_PIXELS = 20;

    // One stimulus row: a file byte, its start flag, and an optional typed-in result
    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       typed;
        t_result    res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // [7:0] data_byte
    logic [0:0]           s_axis_tuser;   // [0] start_of_file
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // [31:0] bgra, [63:32] index, [79:64] width,
                                          // [95:80] height, [97:96] error_code, [103:98] zero
    logic [M_TUSER_W-1:0] m_axis_tuser;   // [1:0] result_kind
    logic                 m_axis_tlast;   // final_item

    // Predicted parser state
    t_phase       ph        = PH_IDLE;
    logic [4:0]   hdr_pos   = '0;
    logic [15:0]  img_w     = '0;
    logic [15:0]  img_h     = '0;
    logic         is32      = 1'b0;
    logic [23:0]  held      = '0;
    logic [1:0]   byte_no   = '0;
    logic [15:0]  col       = '0;
    logic [15:0]  rows_left = '0;
    logic [31:0]  row_base  = '0;

    t_result results_due[$];
    t_row    file_q[$];
    int      bytes_parsed = 0;
    int      errors       = 0;
    int      cycle_cnt    = 0;
    int      in_idle_pct  = 0;
    int      out_idle_pct = 0;

    tga_uncompressed_pixel_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 35;
            default: return 70;
        endcase
    endfunction

    // Non-empty dimension, often the maximum
    function automatic logic [15:0] big_dim();
        if ($urandom_range(0, 1)) return 16'hFFFF;
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic t_result mk_res(t_kind k, logic [31:0] bgra, logic [31:0] idx,
                                       logic [15:0] w, logic [15:0] h, t_err e,
                                       logic last);
        t_result r;
        r.kind       = k;
        r.bgra       = bgra;
        r.index      = idx;
        r.width      = w;
        r.height     = h;
        r.err        = e;
        r.final_item = last;
        return r;
    endfunction

    // Byte-level parse step: advances the predicted state, yields at most one result
    task automatic parse_tga_byte(input logic [7:0] b, input logic sof,
                                  output bit got, output t_result r);
        logic [4:0] pos;
        t_err       fault;
        logic       row_end;
        logic       empty;
        got   = 1'b0;
        r     = '0;
        fault = ERR_NONE;
        if (sof) begin
            ph      = PH_HEADER;
            hdr_pos = '0;
            img_w   = '0;
            img_h   = '0;
            held    = '0;
            byte_no = '0;
        end
        if (ph == PH_HEADER) begin
            pos     = hdr_pos;
            hdr_pos = hdr_pos + 5'd1;
            case (pos)
                HDR_ID_LEN, HDR_MAP_TYPE, HDR_MAP_FIRST_LO, HDR_MAP_FIRST_HI,
                HDR_MAP_LEN_LO, HDR_MAP_LEN_HI, HDR_MAP_DEPTH: begin
                    if (b != 8'd0) fault = ERR_FIXED;
                end
                HDR_IMAGE_TYPE: begin
                    if (b != IMAGE_TYPE_TRUECOLOUR) fault = ERR_FIXED;
                end
                HDR_WIDTH_LO:  img_w = {8'd0, b};
                HDR_WIDTH_HI:  img_w[15:8] = b;
                HDR_HEIGHT_LO: img_h = {8'd0, b};
                HDR_HEIGHT_HI: img_h[15:8] = b;
                HDR_DEPTH:     held = {16'd0, b};
                HDR_DESCRIPTOR: begin
                    if (held[7:0] == DEPTH_24) begin
                        if (b != DESC_24) fault = ERR_DESC;
                        else is32 = 1'b0;
                    end else if (held[7:0] == DEPTH_32) begin
                        if (b != DESC_32) fault = ERR_DESC;
                        else is32 = 1'b1;
                    end else begin
                        fault = ERR_DEPTH;
                    end
                    if (fault == ERR_NONE) begin
                        held      = '0;
                        byte_no   = '0;
                        col       = '0;
                        rows_left = img_h;
                        empty     = (img_w == 16'd0) || (img_h == 16'd0);
                        // bottom row goes to the last buffer row
                        row_base  = empty ? 32'd0 : {16'd0, img_w} * {16'd0, img_h - 16'd1};
                        ph        = empty ? PH_IDLE : PH_PIXELS;
                        got       = 1'b1;
                        r         = mk_res(KIND_HEADER, '0, '0, img_w, img_h, ERR_NONE, empty);
                    end
                end
                default: ;  // origins
            endcase
            if (fault != ERR_NONE) begin
                ph  = PH_IDLE;
                got = 1'b1;
                r   = mk_res(KIND_ERROR, '0, '0, '0, '0, fault, 1'b0);
            end
        end else if (ph == PH_PIXELS) begin
            if (byte_no < (is32 ? 2'd3 : 2'd2)) begin
                held    = held | ({16'd0, b} << (8 * byte_no));
                byte_no = byte_no + 2'd1;
            end else begin
                row_end = ({1'b0, col} + 17'd1) >= {1'b0, img_w};
                got     = 1'b1;
                r       = mk_res(KIND_PIXEL,
                                 is32 ? {b, held} : {ALPHA_OPAQUE, b, held[15:0]},
                                 row_base + {16'd0, col}, img_w, img_h, ERR_NONE,
                                 (rows_left <= 16'd1) && row_end);
                held    = '0;
                byte_no = '0;
                if (row_end) begin
                    col       = '0;
                    rows_left = rows_left - 16'd1;
                    row_base  = row_base - {16'd0, img_w};
                end else begin
                    col = col + 16'd1;
                end
                if (r.final_item) ph = PH_IDLE;
            end
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic sof);
        t_row w;
        w       = '0;
        w.data  = b;
        w.sof   = sof;
        file_q.push_back(w);
    endtask

    task automatic add_checked(input logic [7:0] b, input logic sof, input t_result res);
        t_row w;
        w.data  = b;
        w.sof   = sof;
        w.typed = 1'b1;
        w.res   = res;
        file_q.push_back(w);
    endtask

    // Random file: mostly well formed, some broken headers, truncations and stray bytes
    task automatic build_file();
        logic [7:0]  hdr [0:17];
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  desc;
        int          sel;
        int          fault;
        int          pos;
        int          n_hdr;
        int          n_pix;
        int          bpp;
        file_q.delete();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) add_row(8'($urandom_range(0, 255)), 1'b0);

        sel = $urandom_range(0, 99);
        if (sel < 75) begin
            w = 16'($urandom_range(1, 12));
            h = 16'($urandom_range(1, 6));
        end else if (sel < 87) begin
            // empty image
            w = big_dim();
            h = 16'd0;
            if ($urandom_range(0, 1)) begin
                h = w;
                w = 16'd0;
            end
            if ($urandom_range(0, 3) == 0) w = 16'd0;
        end else begin
            w = big_dim();
            h = big_dim();
        end
        bpp = $urandom_range(0, 1) ? 4 : 3;

        for (pos = 0; pos < 18; pos++) hdr[pos] = 8'd0;
        hdr[HDR_IMAGE_TYPE] = IMAGE_TYPE_TRUECOLOUR;
        for (pos = HDR_MAP_DEPTH + 1; pos < HDR_WIDTH_LO; pos++)
            hdr[pos] = 8'($urandom_range(0, 255));
        hdr[HDR_WIDTH_LO]   = w[7:0];
        hdr[HDR_WIDTH_HI]   = w[15:8];
        hdr[HDR_HEIGHT_LO]  = h[7:0];
        hdr[HDR_HEIGHT_HI]  = h[15:8];
        hdr[HDR_DEPTH]      = (bpp == 4) ? DEPTH_32 : DEPTH_24;
        desc                = (bpp == 4) ? DESC_32 : DESC_24;
        hdr[HDR_DESCRIPTOR] = desc;

        // header faults
        fault = $urandom_range(0, 99);
        n_hdr = 18;
        if (fault < 8) begin
            pos = $urandom_range(HDR_ID_LEN, HDR_MAP_DEPTH);
            if (pos == HDR_IMAGE_TYPE)
                hdr[pos] = IMAGE_TYPE_TRUECOLOUR ^ 8'($urandom_range(1, 255));
            else
                hdr[pos] = 8'($urandom_range(1, 255));
        end else if (fault < 13) begin
            hdr[HDR_DEPTH] = 8'($urandom_range(0, 255));
            if (hdr[HDR_DEPTH] == DEPTH_24 || hdr[HDR_DEPTH] == DEPTH_32)
                hdr[HDR_DEPTH] = hdr[HDR_DEPTH] ^ 8'h01;
        end else if (fault < 18) begin
            if ($urandom_range(0, 1))
                hdr[HDR_DESCRIPTOR] = (bpp == 4) ? DESC_24 : DESC_32;
            else
                hdr[HDR_DESCRIPTOR] = desc ^ 8'($urandom_range(1, 255));
        end else if (fault < 22) begin
            n_hdr = $urandom_range(1, 17);
        end

        for (pos = 0; pos < n_hdr; pos++) add_row(hdr[pos], pos == 0);

        // pixel payload; after an error or an empty header these bytes are dropped
        if (fault < 18) begin
            n_pix = $urandom_range(0, 6);
        end else if (fault < 22) begin
            n_pix = 0;
        end else if (sel < 75) begin
            n_pix = int'(w) * int'(h) * bpp;
            if ($urandom_range(0, 9) == 0) n_pix = $urandom_range(0, n_pix - 1);
            else if ($urandom_range(0, 9) == 0) n_pix += $urandom_range(1, 4);
        end else if (sel < 87) begin
            n_pix = $urandom_range(0, 3);
        end else begin
            n_pix = $urandom_range(0, MAX_TRUNC_PIXELS * bpp);
        end
        repeat (n_pix) add_row(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Present one word, wait for acceptance, then book its predicted result
    task automatic send_word(input t_row w);
        bit      got;
        bit      counts;
        t_result res;
        int      gap;
        gap = idle_gap(in_idle_pct);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w.data;
        s_axis_tuser  <= w.sof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        counts = w.sof || (ph != PH_IDLE);
        parse_tga_byte(w.data, w.sof, got, res);
        if (w.typed)
            results_due.push_back(w.res);
        else if (got)
            results_due.push_back(res);
        if (counts) bytes_parsed++;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
            errors++;
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        add_row(8'hFF, 1'b0);                               // idle, dropped
        add_checked(8'h01, 1'b1,                            // ID length set
                    mk_res(KIND_ERROR, '0, '0, '0, '0, ERR_FIXED, 1'b0));
        add_row(8'h00, 1'b1);
        add_row(8'h00, 1'b0);
        add_checked(8'h03, 1'b0,                            // wrong image type
                    mk_res(KIND_ERROR, '0, '0, '0, '0, ERR_FIXED, 1'b0));
        add_row(8'h00, 1'b1);                               // 1x1, 24 bit
        add_row(8'h00, 1'b0);
        add_row(IMAGE_TYPE_TRUECOLOUR, 1'b0);
        repeat (5) add_row(8'h00, 1'b0);
        repeat (4) add_row(8'hFF, 1'b0);                    // origins, ignored
        add_row(8'h01, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h01, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(DEPTH_24, 1'b0);
        add_checked(DESC_24, 1'b0,
                    mk_res(KIND_HEADER, '0, '0, 16'd1, 16'd1, ERR_NONE, 1'b0));
        add_row(8'h00, 1'b0);
        add_row(8'h80, 1'b0);
        add_checked(8'hFF, 1'b0,                            // alpha filled in
                    mk_res(KIND_PIXEL, {ALPHA_OPAQUE, 8'hFF, 8'h80, 8'h00}, '0,
                           16'd1, 16'd1, ERR_NONE, 1'b1));
        add_row(8'h5A, 1'b0);                               // after last pixel, dropped
        foreach (file_q[i]) send_word(file_q[i]);

        // random files
        while (bytes_parsed < N_ITEMS) begin
            build_file();
            foreach (file_q[i]) send_word(file_q[i]);
        end
        s_axis_tvalid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("** tga_uncompressed_pixel_parser: PASSED **");
        else
            $display("** tga_uncompressed_pixel_parser: FAILED **");
        $finish;
    end

    // Result side back-pressure
    initial begin : result_stall
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = idle_gap(out_idle_pct);
            end
        end
    end

    // Result checking
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected word: expected none, got kind %0h data %0h last %0b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = results_due.pop_front();
                check_field("result_kind",  want.kind,       m_axis_tuser);
                check_field("pixel_bgra",   want.bgra,       m_axis_tdata[31:0]);
                check_field("pixel_index",  want.index,      m_axis_tdata[63:32]);
                check_field("image_width",  want.width,      m_axis_tdata[79:64]);
                check_field("image_height", want.height,     m_axis_tdata[95:80]);
                check_field("error_code",   want.err,        m_axis_tdata[97:96]);
                check_field("final_item",   want.final_item, m_axis_tlast);
            end
        end
    end

    // Cycle count, idling mix and timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 512 == 0) begin
            in_idle_pct  <= pick_pct();
            out_idle_pct <= pick_pct();
        end
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** tga_uncompressed_pixel_parser: FAILED **");
            $finish;
        end
    end

endmodule

// File: tga_uncompressed_pixel_parser.f
rtl/tgap_pkg.sv
rtl/tgap_in_reg.sv
rtl/tgap_parser.sv
rtl/tgap_out_reg.sv
rtl/tga_uncompressed_pixel_parser.sv
bench/tb_tga_uncompressed_pixel_parser.sv
